// ===== sv/tsc_pkg.sv =====
// Package for the token scanner: token kinds, character codes, keyword table,
// the token and bundle types passed between the scanner, the queue and the output stage.
// Depends on nothing.
`default_nettype none
package tsc_pkg;

  localparam int KIND_W = 5;
  localparam int LEN_W = 16;
  localparam int PREFIX_LEN = 7;
  localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
  localparam int KW_COUNT = 7;
  localparam int SLOT_COUNT = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] OUT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_EOF     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_HEX     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_INT     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_STR     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_KW_BASE = 5'd5;
  localparam logic [KIND_W-1:0] KIND_DOT     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd15;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd16;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd19;

  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_EQUAL  = "=";

  localparam logic [7:0] KW_TEXT [KW_COUNT][PREFIX_LEN] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [PREFIX_IDX_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd6, 3'd4
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_HEX,
    MODE_INT,
    MODE_STR,
    MODE_WORD
  } scan_mode_t;

  typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [15:0]       start_res;
    logic [LEN_W-1:0]  length;
  } token_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0]         valid;
    token_t [SLOT_COUNT-1:0]       tok;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [8'd9:8'd13]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [KIND_W-1:0] sym_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_SEMI:   k = KIND_SEMI;
      CH_COMMA:  k = KIND_COMMA;
      CH_EQUAL:  k = KIND_ASSIGN;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

  // A word whose length and leading characters equal a keyword takes that keyword's kind.
  function automatic logic [KIND_W-1:0] word_kind(input prefix_t p, input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    logic              same;
    k = KIND_IDENT;
    if (len < LEN_W'(PREFIX_LEN)) begin
      for (int kw = 0; kw < KW_COUNT; kw++) begin
        same = (KW_LEN[kw] == len[PREFIX_IDX_W-1:0]);
        for (int i = 0; i < PREFIX_LEN; i++) begin
          if ((PREFIX_IDX_W'(i) < len[PREFIX_IDX_W-1:0]) && (p[i] != KW_TEXT[kw][i])) begin
            same = 1'b0;
          end
        end
        if (same && (k == KIND_IDENT)) begin
          k = KIND_KW_BASE + KIND_W'(kw);
        end
      end
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] close_kind(input scan_mode_t m, input prefix_t p,
                                                   input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    case (m)
      MODE_ZERO: k = KIND_INT;
      MODE_INT:  k = KIND_INT;
      MODE_HEX:  k = KIND_HEX;
      MODE_STR:  k = KIND_STR;
      MODE_WORD: k = word_kind(p, len);
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tsc_char_if.sv =====
// Character channel of the token scanner: valid/ready handshake, one source byte and the
// character-present and end-of-source flags. Depends on nothing.
`default_nettype none
interface tsc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       char_present;
  logic       end_of_source;

  modport source (output valid, ch, char_present, end_of_source, input ready);
  modport sink (input valid, ch, char_present, end_of_source, output ready);
endinterface
`default_nettype wire

// ===== sv/tsc_token_if.sv =====
// Token channel of the token scanner: valid/ready handshake, one token and its last_of_run flag.
// Depends on nothing.
`default_nettype none
interface tsc_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] start_res;
  logic [15:0] length;
  logic        last_of_run;

  modport source (output valid, kind, start_res, length, last_of_run, input ready);
  modport sink (input valid, kind, start_res, length, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/tsc_front.sv =====
// Scanner front end: classifies each accepted character, keeps the pending token
// and builds the bundle of up to three tokens that the character causes. Uses tsc_pkg.
`default_nettype none
module tsc_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       ch,
  input  logic             char_present,
  input  logic             end_of_source,
  input  logic             q_full,
  output logic             push,
  output tsc_pkg::bundle_t push_data
);
  import tsc_pkg::*;

  localparam int XW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  scan_mode_t             mode_r, mode_step, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_step, pos_nxt, pos_inc;
  logic [OFFSET_BITS-1:0] start_r, start_step, start_nxt;
  logic [LEN_W-1:0]       len_r, len_step, len_nxt, len_inc;
  prefix_t                prefix_r, prefix_nxt;
  logic                   consumed;
  logic                   close_now;
  logic                   char_emit;
  bundle_t                bundle;

  function automatic logic [15:0] sat_out(input logic [OFFSET_BITS-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return (w > XW'(OUT_MAX)) ? OUT_MAX : w[15:0];
  endfunction

  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign len_inc = (len_r == OUT_MAX) ? len_r : len_r + 1'b1;

  always_comb begin
    case (mode_r)
      MODE_ZERO: consumed = (ch == CH_X) || is_digit(ch);
      MODE_HEX:  consumed = is_xdigit(ch);
      MODE_INT:  consumed = is_digit(ch);
      MODE_STR:  consumed = 1'b1;
      MODE_WORD: consumed = is_word(ch);
      default:   consumed = 1'b0;
    endcase
  end

  assign close_now = char_present &&
                     (((mode_r == MODE_STR) && (ch == CH_QUOTE)) ||
                      (!consumed && (mode_r != MODE_IDLE)));
  assign char_emit = char_present && !consumed && !is_space(ch) && !is_digit(ch) &&
                     (ch != CH_QUOTE) && !is_alpha(ch);

  always_comb begin
    mode_step  = mode_r;
    start_step = start_r;
    len_step   = len_r;
    pos_step   = pos_r;
    prefix_nxt = prefix_r;
    if (char_present) begin
      pos_step = pos_inc;
      if (consumed) begin
        case (mode_r)
          MODE_ZERO: begin
            if (ch == CH_X) begin
              mode_step  = MODE_HEX;
              start_step = pos_inc;
              len_step   = '0;
            end else begin
              mode_step = MODE_INT;
              len_step  = LEN_W'(2);
            end
          end
          MODE_STR: begin
            if (ch == CH_QUOTE) begin
              mode_step = MODE_IDLE;
            end else begin
              len_step = len_inc;
            end
          end
          MODE_WORD: begin
            if (len_r < LEN_W'(PREFIX_LEN)) begin
              prefix_nxt[len_r[PREFIX_IDX_W-1:0]] = ch;
            end
            len_step = len_inc;
          end
          default: begin
            len_step = len_inc;
          end
        endcase
      end else begin
        mode_step = MODE_IDLE;
        if (ch == CH_ZERO) begin
          mode_step  = MODE_ZERO;
          start_step = pos_r;
          len_step   = LEN_W'(1);
        end else if (is_digit(ch)) begin
          mode_step  = MODE_INT;
          start_step = pos_r;
          len_step   = LEN_W'(1);
        end else if (ch == CH_QUOTE) begin
          mode_step  = MODE_STR;
          start_step = pos_inc;
          len_step   = '0;
        end else if (is_alpha(ch)) begin
          mode_step     = MODE_WORD;
          start_step    = pos_r;
          len_step      = LEN_W'(1);
          prefix_nxt[0] = ch;
        end
      end
    end
    if (end_of_source) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
    end else begin
      mode_nxt  = mode_step;
      pos_nxt   = pos_step;
      start_nxt = start_step;
      len_nxt   = len_step;
    end
  end

  // Slot 0 closes the pending token, slot 1 is a one-character token or the token
  // closed at end of source, and slot 2 is the end token.
  always_comb begin
    bundle = '0;
    if (close_now) begin
      bundle.valid[0]         = 1'b1;
      bundle.tok[0].kind      = close_kind(mode_r, prefix_r, len_r);
      bundle.tok[0].start_res = sat_out(start_r);
      bundle.tok[0].length    = len_r;
    end
    if (char_emit) begin
      bundle.valid[1]         = 1'b1;
      bundle.tok[1].start_res = sat_out(pos_r);
      if (ch == CH_DOT) begin
        bundle.tok[1].kind   = KIND_DOT;
        bundle.tok[1].length = '0;
      end else begin
        bundle.tok[1].kind   = sym_kind(ch);
        bundle.tok[1].length = (sym_kind(ch) == KIND_EOF) ? '0 : LEN_W'(1);
      end
    end else if (end_of_source && (mode_step != MODE_IDLE)) begin
      bundle.valid[1]         = 1'b1;
      bundle.tok[1].kind      = close_kind(mode_step, prefix_nxt, len_step);
      bundle.tok[1].start_res = sat_out(start_step);
      bundle.tok[1].length    = len_step;
    end
    if (end_of_source) begin
      bundle.valid[2]         = 1'b1;
      bundle.tok[2].kind      = KIND_EOF;
      bundle.tok[2].start_res = sat_out(pos_step);
      bundle.tok[2].length    = '0;
    end
  end

  assign push      = accept && (bundle.valid != '0);
  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_r <= prefix_nxt;
    end
  end

`ifndef SYNTHESIS
  // The end of a source text leaves the scanner as reset leaves it.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_source |=> (mode_r == MODE_IDLE) && (pos_r == '0))
    else $error("scanner state not cleared after end of source");

  // Nothing is pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("bundle pushed while the queue is full");
`endif

endmodule
`default_nettype wire

// ===== sv/tsc_queue.sv =====
// Short queue of token bundles between the scanner front end and the output stage.
// Uses tsc_pkg.
`default_nettype none
module tsc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsc_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output tsc_pkg::bundle_t head,
  output logic             nonempty
);
  import tsc_pkg::*;

  bundle_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== sv/tsc_back.sv =====
// Output stage: walks the valid slots of the head bundle, one token per transfer,
// into a registered output and marks the last token of each bundle. Uses tsc_pkg.
`default_nettype none
module tsc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  tsc_pkg::bundle_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output tsc_pkg::token_t  out_tok,
  output logic             out_last
);
  import tsc_pkg::*;

  logic [SLOT_COUNT-1:0] sent_r;
  logic [SLOT_COUNT-1:0] remaining;
  logic [SLOT_COUNT-1:0] sel_mask;
  logic [1:0]            sel_idx;
  logic                  last;
  logic                  load;
  logic                  out_valid_r;
  token_t                out_tok_r;
  logic                  out_last_r;

  assign remaining = q_head.valid & ~sent_r;

  always_comb begin
    if (remaining[0]) begin
      sel_idx = 2'd0;
    end else if (remaining[1]) begin
      sel_idx = 2'd1;
    end else begin
      sel_idx = 2'd2;
    end
    sel_mask = SLOT_COUNT'(1) << sel_idx;
  end

  assign last = ((remaining & ~sel_mask) == '0);
  assign load = q_nonempty && (!out_valid_r || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sent_r      <= last ? '0 : (sent_r | sel_mask);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= q_head.tok[sel_idx];
      out_last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  // A queued bundle always has a token left that has not yet been sent.
  a_head_has_token: assert property (@(posedge clk) disable iff (!rst_n)
    q_nonempty |-> (remaining != '0))
    else $error("head bundle has no token left to send");
`endif

endmodule
`default_nettype wire

// ===== sv/token_scanner_top.sv =====
// Token scanner top level: a character channel in, a token channel out.
// Depends on tsc_pkg, tsc_char_if, tsc_token_if, tsc_front, tsc_queue and tsc_back.
//
// The scanner takes one source character per cycle while the queue is not full and turns
// the text into tokens of kind, start offset and length, skipping whitespace and checking
// words against seven keywords. A character is classified in the cycle it is transferred;
// the up to three tokens it causes travel together as one bundle through a four-entry queue
// to the output register, which sends one token per cycle while the receiver is ready; the
// first token of a character is held in a queue entry and then in the output register. A
// character that causes several tokens holds the output until each is sent; the queue takes
// further characters meanwhile until it fills. The last token caused by a character carries
// last_of_run. No clearing pass follows reset; characters are taken once reset is released.
`default_nettype none
module token_scanner_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  tsc_char_if.sink      in_stream,
  tsc_token_if.source   out_stream
);
  import tsc_pkg::*;

  logic    accept;
  logic    push;
  logic    q_full;
  logic    q_nonempty;
  logic    pop;
  bundle_t push_data;
  bundle_t q_head;
  token_t  out_tok;
  logic    out_last;
  logic    out_valid;

  assign in_stream.ready = !q_full;
  assign accept          = in_stream.valid && !q_full;

  tsc_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .ch            (in_stream.ch),
    .char_present  (in_stream.char_present),
    .end_of_source (in_stream.end_of_source),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  tsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  tsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_stream.ready),
    .out_tok    (out_tok),
    .out_last   (out_last)
  );

  assign out_stream.valid       = out_valid;
  assign out_stream.kind        = out_tok.kind;
  assign out_stream.start_res   = out_tok.start_res;
  assign out_stream.length      = out_tok.length;
  assign out_stream.last_of_run = out_last;

endmodule
`default_nettype wire
